>>> rtl/swum_pkg.sv
// Shared types and constants for the sliding window usage meter.
// No dependencies; the top level refers to it by scoped names.
package swum_pkg;

  localparam int unsigned HIST_DEPTH = 512;
  localparam int unsigned PTR_W      = $clog2(HIST_DEPTH);
  localparam int unsigned CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 2'd2;

  localparam logic [DATA_W-1:0] SHORT_WINDOW_RST    = 32'd3600000;
  localparam logic [DATA_W-1:0] LONG_WINDOW_RST     = 32'd18000000;
  localparam logic [DATA_W-1:0] SAMPLE_INTERVAL_RST = 32'd60000;

  typedef struct packed {
    logic [DATA_W-1:0] counter_reading;
    logic [DATA_W-1:0] time_ms;
  } in_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] total_out;
    logic [DATA_W-1:0] short_window_sum;
    logic [DATA_W-1:0] long_window_sum;
  } out_rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0] sample_time;
    logic [DATA_W-1:0] sample_total;
  } hist_entry_t;

endpackage

>>> rtl/sliding_window_usage_meter.sv
// Sliding window usage meter: running total, ring history of samples, two window sums.
// Sequence: an update state, a scan state (N reads newest first, then the last compare
// and exit), then a result state that waits while the result register is held; N is the
// fill count after the update (at most 512). One request is handled at a time, set by the
// single history read port; input stalls while busy. Reset: async active low to
// reset values; history not cleared, only counted entries are read. Depends on swum_pkg.
module sliding_window_usage_meter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [swum_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [swum_pkg::DATA_W-1:0]         cfg_wdata_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  swum_pkg::in_req_t                   in_req_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output swum_pkg::out_rsp_t                  out_rsp_o
);

  localparam int unsigned PTR_W  = swum_pkg::PTR_W;
  localparam int unsigned CNT_W  = swum_pkg::CNT_W;
  localparam int unsigned DATA_W = swum_pkg::DATA_W;

  // sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPDATE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DONE   = 3'd3;

  logic [2:0]        state_q, state_d;

  // configuration
  logic [DATA_W-1:0] short_win_q, long_win_q, interval_q;

  // meter state
  logic              anchored_q, anchored_d;
  logic [DATA_W-1:0] last_reading_q, last_reading_d;
  logic [DATA_W-1:0] total_q, total_d;
  logic [DATA_W-1:0] last_sample_q, last_sample_d;
  logic [PTR_W-1:0]  wp_q, wp_d;
  logic [CNT_W-1:0]  fill_q, fill_d;

  // per-request working registers
  logic [DATA_W-1:0] now_q, now_d;
  logic [DATA_W-1:0] cut_s_q, cut_s_d, cut_l_q, cut_l_d;
  logic [PTR_W-1:0]  rp_q, rp_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              rd_vld_q, rd_vld_d;
  logic              found_s_q, found_s_d, found_l_q, found_l_d;
  logic [DATA_W-1:0] base_s_q, base_s_d, base_l_q, base_l_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  swum_pkg::out_rsp_t   out_rsp_q, out_rsp_d;

  // history memory: one write port, one registered read port
  swum_pkg::hist_entry_t hist_mem_q [swum_pkg::HIST_DEPTH];
  swum_pkg::hist_entry_t rd_data_q;
  logic                  mem_we;
  logic                  rd_issue;

  logic              in_accept;
  logic              take_sample;
  logic [PTR_W-1:0]  wp_prev;
  logic [PTR_W-1:0]  wp_next;
  logic [PTR_W-1:0]  rp_prev;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Sample when the history is empty or the interval has elapsed (wrapping difference).
  assign take_sample = (fill_q == '0) || ((now_q - last_sample_q) >= interval_q);

  assign wp_prev = (wp_q == '0) ? PTR_W'(swum_pkg::HIST_DEPTH - 1) : wp_q - 1'b1;
  assign wp_next = (wp_q == PTR_W'(swum_pkg::HIST_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_prev = (rp_q == '0) ? PTR_W'(swum_pkg::HIST_DEPTH - 1) : rp_q - 1'b1;

  assign mem_we   = (state_q == ST_UPDATE) && take_sample;
  assign rd_issue = (state_q == ST_SCAN) && (cnt_q != '0);

  always_comb begin
    state_d        = state_q;
    anchored_d     = anchored_q;
    last_reading_d = last_reading_q;
    total_d        = total_q;
    last_sample_d  = last_sample_q;
    wp_d           = wp_q;
    fill_d         = fill_q;
    now_d          = now_q;
    cut_s_d        = cut_s_q;
    cut_l_d        = cut_l_q;
    rp_d           = rp_q;
    cnt_d          = cnt_q;
    rd_vld_d       = 1'b0;
    found_s_d      = found_s_q;
    found_l_d      = found_l_q;
    base_s_d       = base_s_q;
    base_l_d       = base_l_q;
    out_valid_d    = out_valid_q;
    out_rsp_d      = out_rsp_q;

    // drop the result once the far side takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          // add the increase unless the source restarted or this is the first reading
          if (anchored_q && (in_req_i.counter_reading >= last_reading_q)) begin
            total_d = total_q + (in_req_i.counter_reading - last_reading_q);
          end
          last_reading_d = in_req_i.counter_reading;
          anchored_d     = 1'b1;
          now_d          = in_req_i.time_ms;
          state_d        = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // append the sample and set up the newest-first scan
        if (take_sample) begin
          last_sample_d = now_q;
          wp_d          = wp_next;
          rp_d          = wp_q;
          if (fill_q != CNT_W'(swum_pkg::HIST_DEPTH)) begin
            fill_d = fill_q + 1'b1;
            cnt_d  = fill_q + 1'b1;
          end else begin
            cnt_d  = fill_q;
          end
        end else begin
          rp_d  = wp_prev;
          cnt_d = fill_q;
        end
        cut_s_d   = (now_q > short_win_q) ? now_q - short_win_q : '0;
        cut_l_d   = (now_q > long_win_q)  ? now_q - long_win_q  : '0;
        found_s_d = 1'b0;
        found_l_d = 1'b0;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        // issue stage: one read a cycle, newest to oldest
        if (rd_issue) begin
          rd_vld_d = 1'b1;
          rp_d     = rp_prev;
          cnt_d    = cnt_q - 1'b1;
        end
        // compare stage: each window keeps the first entry at or before its cutoff,
        // otherwise ends on the oldest entry
        if (rd_vld_q) begin
          if (!found_s_q) begin
            base_s_d  = rd_data_q.sample_total;
            found_s_d = (rd_data_q.sample_time <= cut_s_q);
          end
          if (!found_l_q) begin
            base_l_d  = rd_data_q.sample_total;
            found_l_d = (rd_data_q.sample_time <= cut_l_q);
          end
        end
        if ((cnt_q == '0) && !rd_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                = 1'b1;
          out_rsp_d.total_out        = total_q;
          out_rsp_d.short_window_sum = total_q - base_s_q;
          out_rsp_d.long_window_sum  = total_q - base_l_q;
          state_d                    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      short_win_q    <= swum_pkg::SHORT_WINDOW_RST;
      long_win_q     <= swum_pkg::LONG_WINDOW_RST;
      interval_q     <= swum_pkg::SAMPLE_INTERVAL_RST;
      anchored_q     <= 1'b0;
      last_reading_q <= '1;
      total_q        <= '0;
      last_sample_q  <= '0;
      wp_q           <= '0;
      fill_q         <= '0;
      cnt_q          <= '0;
      rd_vld_q       <= 1'b0;
      found_s_q      <= 1'b0;
      found_l_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      anchored_q     <= anchored_d;
      last_reading_q <= last_reading_d;
      total_q        <= total_d;
      last_sample_q  <= last_sample_d;
      wp_q           <= wp_d;
      fill_q         <= fill_d;
      cnt_q          <= cnt_d;
      rd_vld_q       <= rd_vld_d;
      found_s_q      <= found_s_d;
      found_l_q      <= found_l_d;
      out_valid_q    <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          swum_pkg::CFG_SHORT_WINDOW:    short_win_q <= cfg_wdata_i;
          swum_pkg::CFG_LONG_WINDOW:     long_win_q  <= cfg_wdata_i;
          swum_pkg::CFG_SAMPLE_INTERVAL: interval_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    cut_s_q   <= cut_s_d;
    cut_l_q   <= cut_l_d;
    rp_q      <= rp_d;
    base_s_q  <= base_s_d;
    base_l_q  <= base_l_d;
    out_rsp_q <= out_rsp_d;
  end

  // history memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem_q[wp_q] <= '{sample_time: now_q, sample_total: total_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rd_data_q <= hist_mem_q[rp_q];
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(swum_pkg::HIST_DEPTH))
    else $error("history fill count exceeds depth");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the result state");

  a_read_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> ($past(cnt_q) != '0) && $past(state_q == ST_SCAN))
    else $error("history read without a pending count");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |=> (fill_q != '0) && (cnt_q != '0))
    else $error("scan starts on an empty history");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_UPDATE) && anchored_q)
    else $error("accepted request did not start an update");
`endif

endmodule
